// ----- src/fapsch_pkg.sv -----
// Types and constants shared by the poll scheduler modules.
`default_nettype none
package fapsch_pkg;

  // Input opcodes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_FOCUS  = 3'd1;
  localparam logic [2:0] OP_PRIO   = 3'd2;
  localparam logic [2:0] OP_LOADED = 3'd3;
  localparam logic [2:0] OP_BOOT   = 3'd4;

  // Request kinds
  localparam logic REQ_PRICE = 1'b0;
  localparam logic REQ_CHART = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_ACTIVE  = 2'd0;
  localparam logic [1:0] CFG_FOCUS   = 2'd1;
  localparam logic [1:0] CFG_BACKGND = 2'd2;
  localparam logic [1:0] CFG_SWITCH  = 2'd3;

  // Most results one input may cause
  localparam logic [4:0] RESULT_LIMIT = 5'd18;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] now_ms;
    logic [3:0]  token_index;
    logic [3:0]  focus_index;
  } in_word_t;

  typedef struct packed {
    logic       request_kind;
    logic [3:0] target_index;
    logic       last_request;
  } out_word_t;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_FOCUS,
    CMD_PRIO,
    CMD_LOADED,
    CMD_BOOT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] now;
    logic [3:0]  tok;
    logic [3:0]  foc;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_push_t;

  typedef struct packed {
    logic [31:0] focus_period;
    logic [31:0] bg_period;
    logic [31:0] sw_delay;
  } sched_cfg_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_PEND,
    BK_PRIO,
    BK_CSCAN,
    BK_FOCRD,
    BK_FOCCMP,
    BK_BG,
    BK_BOOTP,
    BK_BOOTC,
    BK_FLUSH
  } back_state_t;

endpackage
`default_nettype wire

// ----- src/fapsch_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fapsch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- src/fapsch_front.sv -----
// Front end: accepts input words, drops meaningless ones and classifies the rest.
`default_nettype none
module fapsch_front #(
  parameter int DEPTH = 16
) (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fapsch_pkg::in_word_t in_word,
  input  logic [4:0]           act_n,
  input  logic                 q_full,
  output fapsch_pkg::q_push_t  q_wr
);
  import fapsch_pkg::*;

  localparam logic [4:0] DEPTH_L = 5'(DEPTH);

  logic acc;
  logic tok_ok;
  logic prio_ok;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign tok_ok   = {1'b0, in_word.token_index} < DEPTH_L;
  assign prio_ok  = {1'b0, in_word.token_index} < act_n;

  always_comb begin
    q_wr          = '0;
    q_wr.cmd.now  = in_word.now_ms;
    q_wr.cmd.tok  = in_word.token_index;
    q_wr.cmd.foc  = in_word.focus_index;
    q_wr.cmd.kind = CMD_TICK;
    case (in_word.opcode)
      OP_TICK: begin
        q_wr.push = acc;
      end
      OP_FOCUS: begin
        q_wr.push     = acc && tok_ok;
        q_wr.cmd.kind = CMD_FOCUS;
      end
      OP_PRIO: begin
        q_wr.push     = acc && prio_ok;
        q_wr.cmd.kind = CMD_PRIO;
      end
      OP_LOADED: begin
        q_wr.push     = acc && tok_ok;
        q_wr.cmd.kind = CMD_LOADED;
      end
      OP_BOOT: begin
        q_wr.push     = acc;
        q_wr.cmd.kind = CMD_BOOT;
      end
      default: begin
        q_wr.push = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/fapsch_cmdq.sv -----
// Short command queue between the front and back ends.
`default_nettype none
module fapsch_cmdq (
  input  logic                clk,
  input  logic                rst_n,
  input  fapsch_pkg::q_push_t wr,
  output logic                full,
  output logic                q_valid,
  output fapsch_pkg::cmd_t    q_data,
  input  logic                pop
);
  import fapsch_pkg::*;

  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign q_valid = (cnt_r != '0);
  assign q_data  = entry_r[rd_ptr_r];
  assign do_push = wr.push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wr.cmd;
    end
  end

endmodule
`default_nettype wire

// ----- src/fapsch_back.sv -----
// Back end: sequencer that executes commands and issues fetch requests.
`default_nettype none
module fapsch_back #(
  parameter int DEPTH            = 16,
  parameter int BOOT_CHART_COUNT = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  fapsch_pkg::cmd_t        q_data,
  output logic                    q_pop,
  input  logic [4:0]              act_n,
  input  fapsch_pkg::sched_cfg_t  cfg,
  output logic                    out_valid,
  input  logic                    out_stall,
  output fapsch_pkg::out_word_t   out_word,
  output fapsch_pkg::back_stat_t  stat
);
  import fapsch_pkg::*;

  localparam int         IDX_W   = $clog2(DEPTH);
  localparam logic [4:0] DEPTH_L = 5'(DEPTH);
  localparam logic [4:0] BCC_L   = 5'(BOOT_CHART_COUNT);

  back_state_t      state_r, state_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [3:0]       foc_r, foc_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic [3:0]       pend_idx_r, pend_idx_nxt;
  logic [31:0]      fct_r, fct_nxt;
  logic             prio_vld_r, prio_vld_nxt;
  logic [3:0]       prio_idx_r, prio_idx_nxt;
  logic [DEPTH-1:0] mark_r, mark_nxt;
  logic [DEPTH-1:0] lft_vld_r, lft_vld_nxt;
  logic [4:0]       scan_r, scan_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [3:0]       cmp_idx_r, cmp_idx_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             hold_vld_r, hold_vld_nxt;
  logic             hold_kind_r, hold_kind_nxt;
  logic [3:0]       hold_idx_r, hold_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  logic             gen;
  logic             gen_kind;
  logic [3:0]       gen_idx;
  logic             flush;
  logic             re;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] mark_addr;
  logic             mark_sel;
  logic             push_req;
  logic             slot_free;
  logic             step_ok;
  logic             lft_we;
  logic [31:0]      ram_q;
  logic [31:0]      lft_q;
  logic [31:0]      age;
  logic             focus_ok;
  logic             pend_due;
  logic             pend_fire;
  logic             prio_hit;
  logic             cscan_end;
  logic             cscan_hit;
  logic             foc_hit;
  logic             bg_hit;
  logic             scan_end;
  logic             bootc_go;

  // Condition terms
  assign mark_addr = (state_r == BK_PRIO) ? prio_idx_r[IDX_W-1:0] : scan_r[IDX_W-1:0];
  assign mark_sel  = mark_r[mark_addr];
  assign focus_ok  = {1'b0, foc_r} < DEPTH_L;
  assign pend_due  = (now_r - fct_r) >= cfg.sw_delay;
  assign pend_fire = pend_vld_r && (pend_idx_r == foc_r) && pend_due;
  assign prio_hit  = prio_vld_r && ({1'b0, prio_idx_r} < act_n) && !mark_sel;
  assign scan_end  = scan_r >= act_n;
  assign cscan_end = scan_end;
  assign cscan_hit = !scan_end && !mark_sel;
  assign lft_q     = rd_vld_r ? ram_q : 32'd0;
  assign age       = now_r - lft_q;
  assign foc_hit   = age >= cfg.focus_period;
  assign bg_hit    = cmp_vld_r && !(focus_ok && (cmp_idx_r == foc_r))
                     && (age >= cfg.bg_period);
  assign bootc_go  = (scan_r < BCC_L) && !scan_end && (cnt_r < RESULT_LIMIT);

  // Sequencer outputs
  always_comb begin
    gen      = 1'b0;
    gen_kind = REQ_PRICE;
    gen_idx  = '0;
    flush    = 1'b0;
    re       = 1'b0;
    raddr    = scan_r[IDX_W-1:0];
    q_pop    = 1'b0;
    case (state_r)
      BK_IDLE: begin
        q_pop = q_valid;
      end
      BK_PEND: begin
        gen     = pend_fire;
        gen_idx = pend_idx_r;
      end
      BK_PRIO: begin
        gen      = prio_hit;
        gen_kind = REQ_CHART;
        gen_idx  = prio_idx_r;
      end
      BK_CSCAN: begin
        gen      = cscan_hit;
        gen_kind = REQ_CHART;
        gen_idx  = scan_r[3:0];
      end
      BK_FOCRD: begin
        re    = focus_ok;
        raddr = foc_r[IDX_W-1:0];
      end
      BK_FOCCMP: begin
        gen     = foc_hit;
        gen_idx = foc_r;
      end
      BK_BG: begin
        gen     = bg_hit;
        gen_idx = cmp_idx_r;
        re      = !bg_hit && !scan_end;
      end
      BK_BOOTP: begin
        gen     = !scan_end;
        gen_idx = scan_r[3:0];
      end
      BK_BOOTC: begin
        gen      = bootc_go;
        gen_kind = REQ_CHART;
        gen_idx  = scan_r[3:0];
      end
      BK_FLUSH: begin
        flush = 1'b1;
      end
      default: begin
        gen = 1'b0;
      end
    endcase
  end

  // A new request pushes the held one out; flush pushes it out marked last.
  assign slot_free = !out_valid_r || !out_stall;
  assign push_req  = hold_vld_r && (gen || flush);
  assign step_ok   = !push_req || slot_free;
  assign lft_we    = gen && step_ok && (gen_kind == REQ_PRICE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_data.kind == CMD_TICK) begin
            state_nxt = BK_PEND;
          end else if (q_data.kind == CMD_BOOT) begin
            state_nxt = BK_BOOTP;
          end
        end
      end
      BK_PEND: begin
        if (step_ok) begin
          state_nxt = BK_PRIO;
        end
      end
      BK_PRIO: begin
        if (step_ok) begin
          state_nxt = prio_hit ? BK_FOCRD : BK_CSCAN;
        end
      end
      BK_CSCAN: begin
        if (step_ok && (cscan_end || cscan_hit)) begin
          state_nxt = BK_FOCRD;
        end
      end
      BK_FOCRD: begin
        state_nxt = focus_ok ? BK_FOCCMP : BK_BG;
      end
      BK_FOCCMP: begin
        if (step_ok) begin
          state_nxt = BK_BG;
        end
      end
      BK_BG: begin
        if (step_ok && (bg_hit || scan_end)) begin
          state_nxt = BK_FLUSH;
        end
      end
      BK_BOOTP: begin
        if (step_ok && scan_end) begin
          state_nxt = BK_BOOTC;
        end
      end
      BK_BOOTC: begin
        if (step_ok && !bootc_go) begin
          state_nxt = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (step_ok) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Register next values
  always_comb begin
    now_nxt       = now_r;
    foc_nxt       = foc_r;
    pend_vld_nxt  = pend_vld_r;
    pend_idx_nxt  = pend_idx_r;
    fct_nxt       = fct_r;
    prio_vld_nxt  = prio_vld_r;
    prio_idx_nxt  = prio_idx_r;
    mark_nxt      = mark_r;
    lft_vld_nxt   = lft_vld_r;
    scan_nxt      = scan_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    cnt_nxt       = cnt_r;
    rd_vld_nxt    = rd_vld_r;
    hold_vld_nxt  = hold_vld_r;
    hold_kind_nxt = hold_kind_r;
    hold_idx_nxt  = hold_idx_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;

    if (q_pop) begin
      now_nxt  = q_data.now;
      foc_nxt  = q_data.foc;
      scan_nxt = '0;
      cnt_nxt  = '0;
      case (q_data.kind)
        CMD_FOCUS: begin
          pend_vld_nxt = 1'b1;
          pend_idx_nxt = q_data.tok;
          fct_nxt      = q_data.now;
        end
        CMD_PRIO: begin
          prio_vld_nxt = 1'b1;
          prio_idx_nxt = q_data.tok;
        end
        CMD_LOADED: begin
          mark_nxt[q_data.tok[IDX_W-1:0]] = 1'b1;
        end
        default: begin
          cnt_nxt = '0;
        end
      endcase
    end

    // Drop the pending switch once it is cancelled or served
    if (state_r == BK_PEND && step_ok && pend_vld_r && ((pend_idx_r != foc_r) || pend_due)) begin
      pend_vld_nxt = 1'b0;
    end

    if (lft_we) begin
      lft_vld_nxt[gen_idx[IDX_W-1:0]] = 1'b1;
    end

    if (re) begin
      rd_vld_nxt = lft_vld_r[raddr];
    end

    case (state_r)
      BK_PRIO: begin
        scan_nxt = '0;
      end
      BK_CSCAN: begin
        if (step_ok && !cscan_end && !cscan_hit) begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      BK_FOCRD, BK_FOCCMP: begin
        scan_nxt    = '0;
        cmp_vld_nxt = 1'b0;
      end
      BK_BG: begin
        if (re) begin
          scan_nxt    = scan_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_r[3:0];
        end
      end
      BK_BOOTP: begin
        if (scan_end) begin
          scan_nxt = '0;
        end else if (step_ok) begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      BK_BOOTC: begin
        if (gen && step_ok) begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      default: begin
        cmp_vld_nxt = cmp_vld_r;
      end
    endcase

    if (gen && step_ok) begin
      cnt_nxt       = cnt_r + 1'b1;
      hold_vld_nxt  = 1'b1;
      hold_kind_nxt = gen_kind;
      hold_idx_nxt  = gen_idx;
    end else if (flush && step_ok) begin
      hold_vld_nxt = 1'b0;
    end

    if (push_req && slot_free) begin
      out_valid_nxt             = 1'b1;
      out_word_nxt.request_kind = hold_kind_r;
      out_word_nxt.target_index = hold_idx_r;
      out_word_nxt.last_request = flush;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      pend_vld_r  <= 1'b0;
      prio_vld_r  <= 1'b0;
      mark_r      <= '0;
      lft_vld_r   <= '0;
      cmp_vld_r   <= 1'b0;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_vld_r  <= pend_vld_nxt;
      prio_vld_r  <= prio_vld_nxt;
      mark_r      <= mark_nxt;
      lft_vld_r   <= lft_vld_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    foc_r       <= foc_nxt;
    pend_idx_r  <= pend_idx_nxt;
    fct_r       <= fct_nxt;
    prio_idx_r  <= prio_idx_nxt;
    scan_r      <= scan_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    cnt_r       <= cnt_nxt;
    rd_vld_r    <= rd_vld_nxt;
    hold_kind_r <= hold_kind_nxt;
    hold_idx_r  <= hold_idx_nxt;
    out_word_r  <= out_word_nxt;
  end

  fapsch_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_lft_ram (
    .clk   (clk),
    .we    (lft_we),
    .waddr (gen_idx[IDX_W-1:0]),
    .wdata (now_r),
    .re    (re),
    .raddr (raddr),
    .rdata (ram_q)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign stat.busy = (state_r != BK_IDLE);

endmodule
`default_nettype wire

// ----- src/focus_aware_poll_scheduler_core.sv -----
// Top level of the focus-aware poll scheduler: config registers, front, queue, back.
// A tick's work grows with the n active entries and is dominated by the one-entry-per-cycle
//   chart scan, which holds while the output stalls, and the background scan through the fetch-time RAM.
// Boot walks a price scan over the entries, then a chart scan; other words are taken by the back while it idles.
// Throughput: the back runs one word at a time; a two-word queue decouples the input side.
// Reset: synchronous, active low; marks and fetch-time valid bits clear at once, no sweep.
`default_nettype none
module focus_aware_poll_scheduler_core #(
  parameter int MAX_ENTRIES      = 16,
  parameter int BOOT_CHART_COUNT = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  fapsch_pkg::in_word_t  in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output fapsch_pkg::out_word_t out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  import fapsch_pkg::*;

  // Only sixteen entries are addressable by the 4-bit index fields, so
  // storage never needs to be deeper than that.
  localparam int         DEPTH   = (MAX_ENTRIES < 16) ? MAX_ENTRIES : 16;
  localparam logic [4:0] DEPTH_L = 5'(DEPTH);

  logic [4:0]  act_tokens_r, act_tokens_nxt;
  logic [31:0] focus_per_r, focus_per_nxt;
  logic [31:0] bg_per_r, bg_per_nxt;
  logic [31:0] sw_delay_r, sw_delay_nxt;

  logic        cfg_we;
  logic [4:0]  act_n;
  sched_cfg_t  cfg;
  q_push_t     q_wr;
  logic        q_full;
  logic        q_valid;
  cmd_t        q_data;
  logic        q_pop;
  back_stat_t  bk_stat;

  // Configuration: always ready, one register per write.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    act_tokens_nxt = act_tokens_r;
    focus_per_nxt  = focus_per_r;
    bg_per_nxt     = bg_per_r;
    sw_delay_nxt   = sw_delay_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE:  act_tokens_nxt = cfg_data[4:0];
        CFG_FOCUS:   focus_per_nxt  = cfg_data;
        CFG_BACKGND: bg_per_nxt     = cfg_data;
        CFG_SWITCH:  sw_delay_nxt   = cfg_data;
        default:     act_tokens_nxt = act_tokens_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_tokens_r <= 5'd16;
      focus_per_r  <= 32'd10000;
      bg_per_r     <= 32'd600000;
      sw_delay_r   <= 32'd3000;
    end else begin
      act_tokens_r <= act_tokens_nxt;
      focus_per_r  <= focus_per_nxt;
      bg_per_r     <= bg_per_nxt;
      sw_delay_r   <= sw_delay_nxt;
    end
  end

  // Clamp the active count to the entries that have storage.
  assign act_n = (act_tokens_r > DEPTH_L) ? DEPTH_L : act_tokens_r;

  assign cfg.focus_period = focus_per_r;
  assign cfg.bg_period    = bg_per_r;
  assign cfg.sw_delay     = sw_delay_r;

  // Front: drop unknown opcodes and out-of-range indexes, classify the rest.
  fapsch_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .act_n    (act_n),
    .q_full   (q_full),
    .q_wr     (q_wr)
  );

  // Queue: hold classified words until the back is free.
  fapsch_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .full    (q_full),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (q_pop)
  );

  // Back: walk the tick or boot sequence and issue requests through a
  // one-word hold stage (to mark the final request) and an output register.
  fapsch_back #(
    .DEPTH            (DEPTH),
    .BOOT_CHART_COUNT (BOOT_CHART_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .act_n     (act_n),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .stat      (bk_stat)
  );

  // Unknown opcodes never reach the queue.
  a_drop_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_word.opcode > OP_BOOT)) |-> !q_wr.push)
    else $error("unknown opcode queued");

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !q_full)
    else $error("command queue overflow");

  // A fresh result only appears after the back was working on a word.
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bk_stat.busy))
    else $error("result issued while back idle");

endmodule
`default_nettype wire

// ----- sim/focus_aware_poll_scheduler_core_tb.sv -----
// Self-checking testbench for the focus-aware poll scheduler: fetch-plan predictor and scoreboard.
module focus_aware_poll_scheduler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fapsch_pkg::*;

  localparam int          MAX_ENTRIES      = 16;
  localparam int          BOOT_CHARTS      = 2;
  localparam logic [2:0]  OP_TOP           = 3'd7;   // highest code the opcode field can carry
  localparam int          SETTLE_CYCLES    = 120;    // a full tick scan plus queued words, with margin
  localparam int          WATCHDOG_LIMIT   = 4000;
  localparam int          HOLD_OFF_CYCLES  = 400;

  // Predicts the fetch requests of the scheduler and holds those still owed by the block.
  class poll_plan_board;
    logic [4:0]  active_raw;
    logic [31:0] focus_period;
    logic [31:0] bg_period;
    logic [31:0] switch_delay;
    logic [31:0] fetched_at [MAX_ENTRIES];
    bit          chart_done [MAX_ENTRIES];
    bit          pend_valid;
    logic [3:0]  pend_idx;
    logic [31:0] pend_since;
    bit          prio_valid;
    logic [3:0]  prio_idx;
    out_word_t   due_requests [$];
    out_word_t   batch [$];
    int          errors;
    int unsigned requests_seen;

    function new();
      active_raw   = 5'd16;
      focus_period = 32'd10000;
      bg_period    = 32'd600000;
      switch_delay = 32'd3000;
      foreach (fetched_at[i]) begin
        fetched_at[i] = '0;
        chart_done[i] = 1'b0;
      end
      pend_valid    = 1'b0;
      pend_idx      = '0;
      pend_since    = '0;
      prio_valid    = 1'b0;
      prio_idx      = '0;
      errors        = 0;
      requests_seen = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_ACTIVE:  active_raw   = data[4:0];
        CFG_FOCUS:   focus_period = data;
        CFG_BACKGND: bg_period    = data;
        CFG_SWITCH:  switch_delay = data;
        default: ;
      endcase
    endfunction

    function int unsigned entries_in_use();
      return (active_raw > MAX_ENTRIES) ? MAX_ENTRIES : active_raw;
    endfunction

    function logic [31:0] elapsed(logic [31:0] now, logic [31:0] since);
      return now - since;
    endfunction

    function void issue(logic kind, logic [3:0] idx);
      out_word_t r;
      if (batch.size() < RESULT_LIMIT) begin
        r.request_kind = kind;
        r.target_index = idx;
        r.last_request = 1'b0;
        batch.push_back(r);
      end
    endfunction

    function void plan_tick(logic [31:0] now, logic [3:0] focus);
      int unsigned n;
      bit          picked;
      n = entries_in_use();
      // A pending switch survives only while the focus stays on it.
      if (pend_valid) begin
        if (pend_idx != focus) begin
          pend_valid = 1'b0;
        end else if (elapsed(now, pend_since) >= switch_delay) begin
          issue(REQ_PRICE, pend_idx);
          fetched_at[pend_idx] = now;
          pend_valid = 1'b0;
        end
      end
      if (prio_valid && prio_idx < n && !chart_done[prio_idx]) begin
        issue(REQ_CHART, prio_idx);
      end else begin
        picked = 1'b0;
        for (int i = 0; i < n; i++) begin
          if (!picked && !chart_done[i]) begin
            issue(REQ_CHART, 4'(i));
            picked = 1'b1;
          end
        end
      end
      if (elapsed(now, fetched_at[focus]) >= focus_period) begin
        issue(REQ_PRICE, focus);
        fetched_at[focus] = now;
      end
      picked = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!picked && i != focus && elapsed(now, fetched_at[i]) >= bg_period) begin
          issue(REQ_PRICE, 4'(i));
          fetched_at[i] = now;
          picked = 1'b1;
        end
      end
    endfunction

    function void plan_boot(logic [31:0] now);
      int unsigned n;
      n = entries_in_use();
      for (int i = 0; i < n; i++) issue(REQ_PRICE, 4'(i));
      for (int i = 0; i < n; i++) fetched_at[i] = now;
      for (int i = 0; i < BOOT_CHARTS && i < n; i++) issue(REQ_CHART, 4'(i));
    endfunction

    function void accept_word(in_word_t w);
      batch.delete();
      case (w.opcode)
        OP_TICK: plan_tick(w.now_ms, w.focus_index);
        OP_FOCUS: begin
          pend_valid = 1'b1;
          pend_idx   = w.token_index;
          pend_since = w.now_ms;
        end
        OP_PRIO: begin
          if (w.token_index < entries_in_use()) begin
            prio_valid = 1'b1;
            prio_idx   = w.token_index;
          end
        end
        OP_LOADED: chart_done[w.token_index] = 1'b1;
        OP_BOOT: plan_boot(w.now_ms);
        default: ;
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last_request = 1'b1;
      foreach (batch[k]) due_requests.push_back(batch[k]);
    endfunction

    function int outstanding();
      return due_requests.size();
    endfunction

    task report(string what);
      $display("[%0t] request %0d: %s", $realtime, requests_seen, what);
      errors++;
    endtask

    task match_request(out_word_t got);
      out_word_t want;
      if (due_requests.size() == 0) begin
        report($sformatf("unexpected word kind %0d target %0d last %0d",
                         got.request_kind, got.target_index, got.last_request));
      end else begin
        want = due_requests.pop_front();
        if (got.request_kind !== want.request_kind)
          report($sformatf("request_kind %0d, wanted %0d", got.request_kind, want.request_kind));
        if (got.target_index !== want.target_index)
          report($sformatf("target_index %0d, wanted %0d", got.target_index, want.target_index));
        if (got.last_request !== want.last_request)
          report($sformatf("last_request %0d, wanted %0d", got.last_request, want.last_request));
      end
      requests_seen++;
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  poll_plan_board board;

  // Traffic shaping: per-word waits, quiet stretches and the long receiver hold-off.
  int unsigned rx_wait   = 0;
  int unsigned rx_hold   = 0;
  bit          rx_quiet  = 1'b0;
  bit          tx_quiet  = 1'b0;

  // Running stimulus context: the clock the host would report and its focused entry.
  logic [31:0] cur_now   = '0;
  logic [3:0]  cur_focus = '0;

  focus_aware_poll_scheduler_core #(
    .MAX_ENTRIES      (MAX_ENTRIES),
    .BOOT_CHART_COUNT (BOOT_CHARTS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Observe every handshake at the rising edge; values were driven at the previous falling edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.set_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) board.accept_word(in_word);
      if (out_valid && !out_stall) begin
        board.match_request(out_word);
        // Draw the wait before the next word; flip in and out of quiet stretches now and then.
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 19) == 0) rx_quiet = !rx_quiet;
      end
    end
  end

  // Receiver: hold stall high for the drawn wait, or for the whole hold-off when one is requested.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when no handshake of any kind completes for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic in_word_t word_of(logic [2:0] op, logic [31:0] now, logic [3:0] tok,
                                       logic [3:0] foc);
    in_word_t w;
    w.opcode      = op;
    w.now_ms      = now;
    w.token_index = tok;
    w.focus_index = foc;
    return w;
  endfunction

  // Offer one word after a drawn gap and hold it until the block takes it.
  task automatic push_word(in_word_t w);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 19) == 0) tx_quiet = !tx_quiet;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, wait for every owed request, then give the back end time to finish silent words.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.outstanding() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed traffic: ticks on the current focus with the clock advancing, focus
  // changes the ticks then follow, plus priority, loaded reports, boots, clock jumps and noise.
  task automatic random_word(logic [31:0] step_max, output in_word_t w, output bit counts);
    int unsigned pick;
    logic [3:0]  foc;
    logic [2:0]  op;
    pick   = $urandom_range(0, 99);
    counts = 1'b1;
    foc    = cur_focus;
    if (pick < 55) begin
      cur_now = cur_now + $urandom_range(0, step_max);
      if ($urandom_range(0, 9) == 0) foc = 4'($urandom_range(0, 15));
      w = word_of(OP_TICK, cur_now, 4'($urandom_range(0, 15)), foc);
    end else if (pick < 67) begin
      if ($urandom_range(0, 3) != 0) cur_focus = 4'($urandom_range(0, 15));
      w = word_of(OP_FOCUS, cur_now, cur_focus, 4'($urandom_range(0, 15)));
    end else if (pick < 75) begin
      w = word_of(OP_PRIO, cur_now, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    end else if (pick < 80) begin
      w = word_of(OP_LOADED, cur_now, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    end else if (pick < 85) begin
      w = word_of(OP_BOOT, cur_now, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    end else if (pick < 91) begin
      // Jump the clock anywhere, wrap included.
      cur_now = $urandom();
      w = word_of(OP_TICK, cur_now, 4'($urandom_range(0, 15)), foc);
    end else begin
      op     = 3'($urandom_range(int'(OP_BOOT) + 1, int'(OP_TOP)));
      w      = word_of(op, $urandom(), 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      counts = 1'b0;
    end
  endtask

  // Idle the block, load a full register set, then run random words under it.
  task automatic run_phase(logic [31:0] active, logic [31:0] fp, logic [31:0] bg,
                           logic [31:0] sw, logic [31:0] step_max, int unsigned items);
    int unsigned done;
    in_word_t    w;
    bit          counts;
    settle();
    write_reg(CFG_ACTIVE, active);
    write_reg(CFG_FOCUS, fp);
    write_reg(CFG_BACKGND, bg);
    write_reg(CFG_SWITCH, sw);
    done = 0;
    while (done < items) begin
      random_word(step_max, w, counts);
      push_word(w);
      if (counts) done++;
    end
  endtask

  // Hold the receiver off while boots and ticks keep coming, so the queue fills and stalls input.
  task automatic fill_while_held();
    rx_hold = HOLD_OFF_CYCLES;
    push_word(word_of(OP_BOOT, cur_now, '0, cur_focus));
    for (int k = 0; k < 10; k++) begin
      cur_now = cur_now + 32'd2000;
      push_word(word_of(OP_TICK, cur_now, 4'(k), cur_focus));
    end
    push_word(word_of(OP_BOOT, cur_now, 4'hF, cur_focus));
  endtask

  initial begin
    board     = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ACTIVE;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset register values.
    push_word(word_of(OP_TICK, 32'd0, 4'd0, 4'd0));              // first tick: a chart request only, no price due yet
    push_word(word_of(OP_BOOT, 32'd100, 4'd0, 4'd0));            // full boot: hits the result cap
    push_word(word_of(OP_LOADED, 32'd100, 4'd0, 4'd0));
    push_word(word_of(OP_LOADED, 32'd100, 4'hF, 4'hF));
    push_word(word_of(OP_PRIO, 32'd100, 4'd5, 4'd0));
    push_word(word_of(OP_TICK, 32'd20000, 4'd0, 4'd3));          // priority chart, focused due
    push_word(word_of(OP_FOCUS, 32'd20000, 4'd7, 4'd0));
    push_word(word_of(OP_TICK, 32'd21000, 4'd0, 4'd7));          // switch delay not yet spent
    push_word(word_of(OP_TICK, 32'd23000, 4'd0, 4'd7));          // switch fetch exactly on time
    push_word(word_of(OP_FOCUS, 32'd24000, 4'd9, 4'd0));
    push_word(word_of(OP_TICK, 32'd30000, 4'd0, 4'd2));          // focus moved away: cancel
    push_word(word_of(OP_LOADED, 32'd30000, 4'd5, 4'd0));        // priority entry now loaded
    push_word(word_of(OP_TICK, 32'd31000, 4'd0, 4'd2));
    push_word(word_of(OP_TICK, 32'd700000, 4'd0, 4'd4));         // background period run out
    push_word(word_of(OP_TICK, 32'hFFFF_FFF0, 4'd0, 4'd4));
    push_word(word_of(OP_FOCUS, 32'hFFFF_FFF8, 4'd4, 4'd0));
    push_word(word_of(OP_TICK, 32'h0000_0010, 4'd0, 4'd4));      // time wraps past zero
    push_word(word_of(OP_TICK, 32'h0000_0C00, 4'd0, 4'd4));      // switch fetch across the wrap
    push_word(word_of(OP_PRIO, 32'h0000_0C00, 4'hF, 4'hF));      // top entry as priority
    push_word(word_of(3'd5, 32'hFFFF_FFFF, 4'hF, 4'hF));         // unused codes: ignore
    push_word(word_of(OP_TOP, 32'h0, 4'h0, 4'h0));
    push_word(word_of(OP_TICK, 32'hFFFF_FFFF, 4'hA, 4'hF));
    push_word(word_of(OP_BOOT, 32'h8000_0000, 4'h0, 4'h0));
    cur_now = 32'h8000_0000;

    // Register settings, extremes among them: a single entry with zero periods, an
    // oversized count with all-ones periods, no active entries, then random sets.
    run_phase(32'd16, 32'd10000, 32'd600000, 32'd3000, 32'd2500, 30);
    fill_while_held();
    run_phase(32'd1, 32'd0, 32'd0, 32'd0, 32'd3, 25);
    run_phase(32'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 25);
    run_phase(32'd0, 32'd500, 32'd1500, 32'd700, 32'd400, 20);
    run_phase($urandom_range(1, 16), $urandom_range(0, 5000), $urandom_range(0, 20000),
              $urandom_range(0, 3000), 32'd1500, 35);
    run_phase({27'($urandom()), 5'($urandom_range(2, 8))}, $urandom(), $urandom(),
              $urandom(), 32'hFFFF_FFFF, 25);
    settle();

    if (board.errors == 0 && board.outstanding() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
